// File: design/sbc_pkg.sv
// sbc_pkg: shared constants, operation codes and control structs for the
// stars-and-bars counter (binomial coefficient mod 1000000007).
// No dependencies.
package sbc_pkg;

  localparam int COUNT_BITS_DEF = 20;
  localparam int VAL_W          = 30;
  localparam int EXP_BITS       = 30;
  localparam int BIT_W          = 5;

  localparam logic [VAL_W-1:0] MODULUS = 30'd1000000007;
  localparam logic [31:0]      MOD_32  = 32'd1000000007;
  localparam logic [31:0]      MOD2_32 = 32'd2000000014;
  // floor(2^60 / p) for the Barrett reduction
  localparam logic [30:0]      BARRETT_MU = 31'd1152921496;
  // Fermat exponent p-2
  localparam logic [EXP_BITS-1:0] EXP_PM2 = 30'd1000000005;

  // multiplier operand selection
  localparam logic [2:0] OP_NONE = 3'd0;
  localparam logic [2:0] OP_RUN  = 3'd1;
  localparam logic [2:0] OP_PROD = 3'd2;
  localparam logic [2:0] OP_ACC  = 3'd3;
  localparam logic [2:0] OP_SQR  = 3'd4;
  localparam logic [2:0] OP_FIN  = 3'd5;

  // multiplier result destination
  localparam logic [2:0] WR_NONE = 3'd0;
  localparam logic [2:0] WR_RUN  = 3'd1;
  localparam logic [2:0] WR_BASE = 3'd2;
  localparam logic [2:0] WR_ACC  = 3'd3;
  localparam logic [2:0] WR_RES  = 3'd4;

  typedef struct packed {
    logic       load_in;
    logic       mul_go;
    logic [2:0] op;
    logic [2:0] wr;
    logic       init_exp;
    logic       next_bit;
    logic       out_load;
  } sbc_cmd_t;

  typedef struct packed {
    logic n_zero;
    logic cnt_done;
    logic exp_bit;
    logic bit_last;
    logic mul_done;
    logic out_free;
  } sbc_sts_t;

endpackage

// File: design/stars_and_bars_count_mod_prime.sv
// stars_and_bars_count_mod_prime: C(n+m-1, n-1) mod 1000000007, one item at a time.
// Each factorial step is one product through the four-stage modular multiplier,
// and the inverse takes 30 squarings plus 15 multiplies. A new item is taken
// only after the previous result has been loaded into the output register.
// Synchronous active-low reset returns the sequencer to idle and clears out_valid.
module stars_and_bars_count_mod_prime import sbc_pkg::*; #(
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [COUNT_BITS-1:0] in_bins_req,
  input  logic [COUNT_BITS-1:0] in_items,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [VAL_W-1:0]      out_ways
);

  sbc_cmd_t cmd;
  sbc_sts_t sts;

  sbc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  sbc_datapath #(
    .COUNT_BITS (COUNT_BITS)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .sts         (sts),
    .in_bins_req (in_bins_req),
    .in_items    (in_items),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_ways    (out_ways)
  );

`ifndef NO_ASSERTIONS
  a_mul_latency: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.mul_go |-> ##4 sts.mul_done)
    else $error("multiplier result not back after four cycles");

  a_mul_single: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.mul_go |=> !cmd.mul_go)
    else $error("multiplies issued back to back");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input taken while previous item in flight");

  a_ways_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_ways < MODULUS))
    else $error("result not reduced mod p");
`endif

endmodule

// File: design/sbc_modmul.sv
// sbc_modmul: four-stage pipelined multiplier mod 1000000007
// (30x30 product, Barrett quotient, remainder, final correction).
// Depends on sbc_pkg.
module sbc_modmul import sbc_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             go,
  input  logic [VAL_W-1:0] op_a,
  input  logic [VAL_W-1:0] op_b,
  output logic             done,
  output logic [VAL_W-1:0] res
);

  logic [59:0]      prod_r;
  logic [30:0]      q_r;
  logic [31:0]      plo_r;
  logic [31:0]      rem_r;
  logic [VAL_W-1:0] res_r;
  logic [3:0]       vld_r;

  logic [61:0] qm;
  logic [31:0] qp;
  logic [31:0] rem_m1;
  logic [31:0] rem_m2;
  logic [31:0] rem_fix;

  assign qm      = 62'(prod_r[59:29]) * 62'(BARRETT_MU);
  assign qp      = 32'(q_r) * MOD_32;
  assign rem_m1  = rem_r - MOD_32;
  assign rem_m2  = rem_r - MOD2_32;

  always_comb begin
    priority if (rem_r >= MOD2_32) begin
      rem_fix = rem_m2;
    end else if (rem_r >= MOD_32) begin
      rem_fix = rem_m1;
    end else begin
      rem_fix = rem_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[2:0], go};
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= 60'(op_a) * 60'(op_b);
    q_r    <= qm[61:31];
    plo_r  <= prod_r[31:0];
    rem_r  <= plo_r - qp;
    res_r  <= rem_fix[VAL_W-1:0];
  end

  assign done = vld_r[3];
  assign res  = res_r;

endmodule

// File: design/sbc_datapath.sv
// sbc_datapath: operand registers, factor counter, exponent bit pointer,
// output register and the modular multiplier.
// Depends on sbc_pkg and sbc_modmul.
module sbc_datapath import sbc_pkg::*; #(
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  sbc_cmd_t              cmd,
  output sbc_sts_t              sts,
  input  logic [COUNT_BITS-1:0] in_bins_req,
  input  logic [COUNT_BITS-1:0] in_items,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [VAL_W-1:0]      out_ways
);

  localparam int CNT_W = COUNT_BITS + 1;

  logic [COUNT_BITS-1:0] n_r;
  logic [COUNT_BITS-1:0] m_r;
  logic [CNT_W-1:0]      total_r;
  logic [CNT_W-1:0]      cnt_r;
  logic [VAL_W-1:0]      run_r;
  logic [VAL_W-1:0]      fb_r;
  logic [VAL_W-1:0]      fi_r;
  logic [VAL_W-1:0]      base_r;
  logic [VAL_W-1:0]      acc_r;
  logic [VAL_W-1:0]      res_r;
  logic [BIT_W-1:0]      bit_r;
  logic [VAL_W-1:0]      out_ways_r;
  logic                  out_valid_r;

  logic [31:0]      cnt32;
  logic [31:0]      fac32;
  logic [VAL_W-1:0] op_a;
  logic [VAL_W-1:0] op_b;
  logic             mul_done;
  logic [VAL_W-1:0] mul_res;
  logic [CNT_W-1:0] nm1;
  logic [CNT_W-1:0] m_ext;

  assign cnt32 = {{(32-CNT_W){1'b0}}, cnt_r};
  assign fac32 = (cnt32 >= MOD_32) ? (cnt32 - MOD_32) : cnt32;
  assign nm1   = {1'b0, n_r} - CNT_W'(1);
  assign m_ext = {1'b0, m_r};

  always_comb begin
    unique case (cmd.op)
      OP_RUN:  begin op_a = run_r;  op_b = fac32[VAL_W-1:0]; end
      OP_PROD: begin op_a = fb_r;   op_b = fi_r;             end
      OP_ACC:  begin op_a = acc_r;  op_b = base_r;           end
      OP_SQR:  begin op_a = base_r; op_b = base_r;           end
      OP_FIN:  begin op_a = run_r;  op_b = acc_r;            end
      default: begin op_a = '0;     op_b = '0;               end
    endcase
  end

  sbc_modmul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .go    (cmd.mul_go),
    .op_a  (op_a),
    .op_b  (op_b),
    .done  (mul_done),
    .res   (mul_res)
  );

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      n_r     <= in_bins_req;
      m_r     <= in_items;
      total_r <= {1'b0, in_bins_req} + {1'b0, in_items} - CNT_W'(1);
      cnt_r   <= CNT_W'(1);
      run_r   <= VAL_W'(1);
      fb_r    <= VAL_W'(1);
      fi_r    <= VAL_W'(1);
      res_r   <= (in_items == '0) ? VAL_W'(1) : '0;
    end
    if (cmd.init_exp) begin
      acc_r <= VAL_W'(1);
      bit_r <= '0;
    end
    if (cmd.next_bit) begin
      bit_r <= bit_r + BIT_W'(1);
    end
    unique case (cmd.wr)
      WR_RUN: begin
        run_r <= mul_res;
        cnt_r <= cnt_r + CNT_W'(1);
        if (cnt_r == nm1) begin
          fb_r <= mul_res;
        end
        if (cnt_r == m_ext) begin
          fi_r <= mul_res;
        end
      end
      WR_BASE: base_r <= mul_res;
      WR_ACC:  acc_r  <= mul_res;
      WR_RES:  res_r  <= mul_res;
      default: ;
    endcase
    if (cmd.out_load) begin
      out_ways_r <= res_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  assign sts.n_zero   = (n_r == '0);
  assign sts.cnt_done = (cnt_r > total_r);
  assign sts.exp_bit  = EXP_PM2[bit_r];
  assign sts.bit_last = (bit_r == BIT_W'(EXP_BITS - 1));
  assign sts.mul_done = mul_done;
  assign sts.out_free = !out_valid_r || !out_stall;

  assign out_valid = out_valid_r;
  assign out_ways  = out_ways_r;

endmodule

// File: design/sbc_ctrl.sv
// sbc_ctrl: sequencer for the factorial product, Fermat inversion and
// result hand-off; drives datapath commands from datapath status.
// Depends on sbc_pkg.
module sbc_ctrl import sbc_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  sbc_sts_t sts,
  output sbc_cmd_t cmd
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_CHK    = 4'd1;
  localparam logic [3:0] S_RUN    = 4'd2;
  localparam logic [3:0] S_RUN_W  = 4'd3;
  localparam logic [3:0] S_PROD   = 4'd4;
  localparam logic [3:0] S_PROD_W = 4'd5;
  localparam logic [3:0] S_EXP    = 4'd6;
  localparam logic [3:0] S_ACC_W  = 4'd7;
  localparam logic [3:0] S_SQR    = 4'd8;
  localparam logic [3:0] S_SQR_W  = 4'd9;
  localparam logic [3:0] S_FIN    = 4'd10;
  localparam logic [3:0] S_FIN_W  = 4'd11;
  localparam logic [3:0] S_DLV    = 4'd12;

  logic [3:0] state_r;
  logic [3:0] state_nxt;

  always_comb begin
    cmd       = '0;
    cmd.op    = OP_NONE;
    cmd.wr    = WR_NONE;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt   = S_CHK;
        end
      end
      S_CHK: begin
        state_nxt = sts.n_zero ? S_DLV : S_RUN;
      end
      S_RUN: begin
        if (sts.cnt_done) begin
          state_nxt = S_PROD;
        end else begin
          cmd.mul_go = 1'b1;
          cmd.op     = OP_RUN;
          state_nxt  = S_RUN_W;
        end
      end
      S_RUN_W: begin
        if (sts.mul_done) begin
          cmd.wr    = WR_RUN;
          state_nxt = S_RUN;
        end
      end
      S_PROD: begin
        cmd.mul_go = 1'b1;
        cmd.op     = OP_PROD;
        state_nxt  = S_PROD_W;
      end
      S_PROD_W: begin
        if (sts.mul_done) begin
          cmd.wr       = WR_BASE;
          cmd.init_exp = 1'b1;
          state_nxt    = S_EXP;
        end
      end
      S_EXP: begin
        cmd.mul_go = 1'b1;
        if (sts.exp_bit) begin
          cmd.op    = OP_ACC;
          state_nxt = S_ACC_W;
        end else begin
          cmd.op    = OP_SQR;
          state_nxt = S_SQR_W;
        end
      end
      S_ACC_W: begin
        if (sts.mul_done) begin
          cmd.wr    = WR_ACC;
          state_nxt = S_SQR;
        end
      end
      S_SQR: begin
        cmd.mul_go = 1'b1;
        cmd.op     = OP_SQR;
        state_nxt  = S_SQR_W;
      end
      S_SQR_W: begin
        if (sts.mul_done) begin
          cmd.wr       = WR_BASE;
          cmd.next_bit = 1'b1;
          state_nxt    = sts.bit_last ? S_FIN : S_EXP;
        end
      end
      S_FIN: begin
        cmd.mul_go = 1'b1;
        cmd.op     = OP_FIN;
        state_nxt  = S_FIN_W;
      end
      S_FIN_W: begin
        if (sts.mul_done) begin
          cmd.wr    = WR_RES;
          state_nxt = S_DLV;
        end
      end
      S_DLV: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall = (state_r != S_IDLE);

endmodule
